// ===== rtl/core/alrmw_pkg.sv =====
`default_nettype none

package alrmw_pkg;

  // Default sizes of the location table.
  localparam int LOCATIONS_DEF   = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the stream beats.
  localparam int CMD_W   = 2;
  localparam int LOC_W   = 10;
  localparam int DATA_W  = 32;
  localparam int BOP_W   = 3;
  localparam int STAT_W  = 2;
  localparam int LOC_SPAN = 1 << LOC_W;

  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = CMD_W + BOP_W;
  localparam int OUT_TDATA_W = DATA_W;
  localparam int OUT_TUSER_W = STAT_W + 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FOP   = 2'd2;

  // Fetch-op kinds.
  localparam logic [BOP_W-1:0] OP_ADD = 3'd0;
  localparam logic [BOP_W-1:0] OP_SUB = 3'd1;
  localparam logic [BOP_W-1:0] OP_AND = 3'd2;
  localparam logic [BOP_W-1:0] OP_OR  = 3'd3;
  localparam logic [BOP_W-1:0] OP_XOR = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_STORE = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN  = 2'd3;

  // Outcome of one command, from the execute logic to the table writes and the result register.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              success;
    logic              wr_en;
  } exec_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/alrmw_exec.sv =====
`default_nettype none

module alrmw_exec #(
  parameter int VALUE_WIDTH = alrmw_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic [alrmw_pkg::CMD_W-1:0] cmd,
  input  wire logic                        loc_null,
  input  wire logic [alrmw_pkg::BOP_W-1:0] bop,
  input  wire logic [VALUE_WIDTH-1:0]      data_v,
  input  wire logic [VALUE_WIDTH-1:0]      exp_v,
  input  wire logic                        old_valid,
  input  wire logic [VALUE_WIDTH-1:0]      prior_value,
  output alrmw_pkg::exec_ctl_t             ctl,
  output logic      [VALUE_WIDTH-1:0]      wr_value,
  output logic      [VALUE_WIDTH-1:0]      res_value
);
  import alrmw_pkg::*;

  logic [VALUE_WIDTH-1:0] fop_value;
  logic                   fop_known;

  // Fetch-op arithmetic, wrapping at the value width.
  always_comb begin
    fop_known = 1'b1;
    case (bop)
      OP_ADD:  fop_value = prior_value + data_v;
      OP_SUB:  fop_value = prior_value - data_v;
      OP_AND:  fop_value = prior_value & data_v;
      OP_OR:   fop_value = prior_value | data_v;
      OP_XOR:  fop_value = prior_value ^ data_v;
      default: begin
        fop_value = '0;
        fop_known = 1'b0;
      end
    endcase
  end

  // Command decode. The null location wins over every other check.
  always_comb begin
    ctl.status  = ST_OK;
    ctl.success = 1'b0;
    ctl.wr_en   = 1'b0;
    wr_value    = data_v;
    res_value   = '0;
    if (loc_null) begin
      ctl.status = ST_NULL;
    end else begin
      case (cmd)
        CMD_STORE: begin
          ctl.success = 1'b1;
          ctl.wr_en   = 1'b1;
          res_value   = data_v;
        end
        CMD_CAS: begin
          if (!old_valid) begin
            ctl.status = ST_NO_STORE;
          end else begin
            res_value = prior_value;
            if (prior_value == exp_v) begin
              ctl.success = 1'b1;
              ctl.wr_en   = 1'b1;
            end
          end
        end
        CMD_FOP: begin
          if (!old_valid) begin
            ctl.status = ST_NO_STORE;
          end else if (!fop_known) begin
            ctl.status = ST_UNKNOWN;
          end else begin
            ctl.success = 1'b1;
            ctl.wr_en   = 1'b1;
            wr_value    = fop_value;
            res_value   = fop_value;
          end
        end
        default: begin
          ctl.status = ST_UNKNOWN;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/atomic_location_rmw_unit.sv =====
// Atomic read-modify-write unit. Each beat on the input stream carries one
// command (store, compare-and-swap or fetch-op) for one location; each gives
// exactly one result beat. The last value of every location sits in a
// synchronous table, and a second one-bit table marks the locations that
// have been stored. The table is read in the cycle the beat is accepted;
// in the execute state that follows, once the result register is free, the
// result is computed, written back and registered. The input accepts again
// in the cycle after that, so a new command is taken only once the last one
// is through execute; a waiting result holds the next command in execute
// until it leaves. After reset the valid table is cleared one entry per
// cycle, and no command is accepted during that pass.
// Locations wrap modulo LOCATIONS; location 0 is the null location.
`default_nettype none

module atomic_location_rmw_unit #(
  parameter int LOCATIONS   = alrmw_pkg::LOCATIONS_DEF,
  parameter int VALUE_WIDTH = alrmw_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // location[9:0], data_value[41:10], expected_value[73:42], zero[79:74]
  input  wire logic [alrmw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command[1:0], op_kind[4:2]
  input  wire logic [alrmw_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // result_value[31:0]
  output logic      [alrmw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status[1:0], success[2]
  output logic      [alrmw_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import alrmw_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int IW = $clog2(LOCATIONS);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [IW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [LOC_W-1:0]  in_loc;
  logic [IW-1:0]     in_idx;
  logic              in_fire;
  logic              exec_fire;
  logic              clearing;

  logic [CMD_W-1:0]  cmd_r;
  logic [BOP_W-1:0]  bop_r;
  logic              loc_null_r;
  logic [VW-1:0]     data_r;
  logic [VW-1:0]     exp_r;
  logic [IW-1:0]     idx_r;

  logic [VW-1:0]     value_mem [LOCATIONS];
  logic              valid_mem [LOCATIONS];
  logic [VW-1:0]     value_rd_r;
  logic              valid_rd_r;
  logic              valid_we;
  logic [IW-1:0]     valid_wr_idx;

  exec_ctl_t         ctl;
  logic [VW-1:0]     wr_value;
  logic [VW-1:0]     res_value;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_success_r;
  logic [DATA_W-1:0] out_value_r;

  assign in_loc    = in_tdata[LOC_W-1:0];
  assign clearing  = (state_r == S_CLEAR);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // Location to table index: a plain resize when the table covers the whole
  // location range, otherwise a remainder by a reciprocal multiply.
  generate
    if (LOCATIONS >= LOC_SPAN) begin : g_direct
      assign in_idx = IW'(in_loc);
    end else begin : g_wrap
      localparam int RK = 2 * LOC_W;
      localparam int RM = ((1 << RK) + LOCATIONS - 1) / LOCATIONS;
      logic [RK+LOC_W-1:0] prod;
      logic [LOC_W-1:0]    quot;
      logic [2*LOC_W-1:0]  back;
      logic [LOC_W-1:0]    rem;
      always_comb begin
        prod   = (RK+LOC_W)'(in_loc) * (RK+LOC_W)'(RM);
        quot   = prod[RK +: LOC_W];
        back   = (2*LOC_W)'(quot) * (2*LOC_W)'(LOCATIONS);
        rem    = in_loc - back[LOC_W-1:0];
        in_idx = rem[IW-1:0];
      end
    end
  endgenerate

  // Sequencer: clearing pass, idle, execute.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IW'(LOCATIONS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Capture the accepted beat, with values cut to the table width.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r      <= in_tuser[CMD_W-1:0];
      bop_r      <= in_tuser[CMD_W +: BOP_W];
      loc_null_r <= (in_loc == '0);
      data_r     <= VW'(in_tdata[LOC_W +: DATA_W]);
      exp_r      <= VW'(in_tdata[LOC_W+DATA_W +: DATA_W]);
      idx_r      <= in_idx;
    end
  end

  // Value table: written by execute, read when a beat is accepted.
  always_ff @(posedge clk) begin
    if (exec_fire && ctl.wr_en) begin
      value_mem[idx_r] <= wr_value;
    end
    if (in_fire) begin
      value_rd_r <= value_mem[in_idx];
    end
  end

  // Valid table: swept clear after reset, set by every write.
  assign valid_we     = clearing || (exec_fire && ctl.wr_en);
  assign valid_wr_idx = clearing ? clr_cnt_r : idx_r;

  always_ff @(posedge clk) begin
    if (valid_we) begin
      valid_mem[valid_wr_idx] <= !clearing;
    end
    if (in_fire) begin
      valid_rd_r <= valid_mem[in_idx];
    end
  end

  alrmw_exec #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_exec (
    .cmd         (cmd_r),
    .loc_null    (loc_null_r),
    .bop         (bop_r),
    .data_v      (data_r),
    .exp_v       (exp_r),
    .old_valid   (valid_rd_r),
    .prior_value (value_rd_r),
    .ctl         (ctl),
    .wr_value    (wr_value),
    .res_value   (res_value)
  );

  // Result register; it holds while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status_r  <= ctl.status;
      out_success_r <= ctl.success;
      out_value_r   <= DATA_W'(res_value);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_success_r, out_status_r};

endmodule

`default_nettype wire

// ===== rtl/core/alrmw_checker.sv =====
`default_nettype none

module alrmw_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [alrmw_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [alrmw_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import alrmw_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // One command at a time: the input closes right after a beat is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted a beat while a command was executing");

  // After a command is accepted the state register enters execute, and after
  // that the output holds a result, its own or an older one that still waits.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("no result two cycles after a command");

  // Any failing status reports no success and a zero value.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[STAT_W-1:0] != ST_OK) |-> !out_tuser[STAT_W] && (out_tdata == '0))
    else $error("failing status carries success or a value");

endmodule

bind atomic_location_rmw_unit alrmw_checker u_alrmw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== verif/rmw_result_checker.sv =====
module rmw_result_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  // location[9:0], data_value[41:10], expected_value[73:42], zero[79:74]
  input  wire logic [alrmw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command[1:0], op_kind[4:2]
  input  wire logic [alrmw_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  // result_value[31:0]
  input  wire logic [alrmw_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[1:0], success[2]
  input  wire logic [alrmw_pkg::OUT_TUSER_W-1:0] out_tuser,
  output int                                     mismatches,
  output int                                     awaiting,
  output int                                     results_checked,
  output int                                     swap_hits,
  output int                                     swap_misses,
  output int                                     flagged
);
  timeunit 1ns;
  timeprecision 1ps;

  import alrmw_pkg::*;

  // One result beat as the unit should send it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              success;
    logic [DATA_W-1:0] value;
  } rmw_result_t;

  // Shadow of the location table; nothing counts as stored after reset.
  bit [DATA_W-1:0] shadow_value [LOCATIONS_DEF];
  bit              shadow_stored [LOCATIONS_DEF];

  rmw_result_t pending_results [$];
  int n_mismatch, n_checked, n_hit, n_miss, n_flag;

  // Apply one command to the shadow table and return the result it gives.
  function automatic rmw_result_t apply_rmw(
    input logic [CMD_W-1:0]  cmd,
    input logic [LOC_W-1:0]  loc,
    input logic [DATA_W-1:0] operand,
    input logic [DATA_W-1:0] compare,
    input logic [BOP_W-1:0]  bop
  );
    rmw_result_t r;
    int unsigned idx;
    logic [DATA_W-1:0] old;
    logic [DATA_W-1:0] updated;
    r.status = ST_OK;
    r.success = 1'b0;
    r.value = '0;
    updated = '0;
    idx = loc % LOCATIONS_DEF;
    // The null location is rejected before the command is even decoded.
    if (loc == '0) begin
      r.status = ST_NULL;
    end else begin
      case (cmd)
        CMD_STORE: begin
          shadow_value[idx] = operand;
          shadow_stored[idx] = 1'b1;
          r.success = 1'b1;
          r.value = operand;
        end
        CMD_CAS: begin
          if (!shadow_stored[idx]) begin
            r.status = ST_NO_STORE;
          end else begin
            old = shadow_value[idx];
            r.value = old;
            if (old == compare) begin
              shadow_value[idx] = operand;
              r.success = 1'b1;
            end
          end
        end
        CMD_FOP: begin
          if (!shadow_stored[idx]) begin
            r.status = ST_NO_STORE;
          end else begin
            old = shadow_value[idx];
            case (bop)
              OP_ADD: updated = old + operand;
              OP_SUB: updated = old - operand;
              OP_AND: updated = old & operand;
              OP_OR:  updated = old | operand;
              OP_XOR: updated = old ^ operand;
              default: r.status = ST_UNKNOWN;
            endcase
            // An unknown kind leaves the location untouched.
            if (r.status == ST_OK) begin
              shadow_value[idx] = updated;
              r.success = 1'b1;
              r.value = updated;
            end
          end
        end
        default: r.status = ST_UNKNOWN;
      endcase
    end
    return r;
  endfunction

  // Check each result beat against the oldest prediction, then predict
  // for the command beat taken at the same edge.
  always @(posedge clk) begin
    rmw_result_t want;
    rmw_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status = out_tuser[STAT_W-1:0];
        got.success = out_tuser[STAT_W];
        got.value = out_tdata;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with none expected: status %0d success %0b value %h",
                   $time, got.status, got.success, got.value);
          n_mismatch++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (got.status != want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            n_mismatch++;
          end
          if (got.success != want.success) begin
            $display("%0t: success expected %0b, got %0b", $time, want.success, got.success);
            n_mismatch++;
          end
          if (got.value != want.value) begin
            $display("%0t: result_value expected %h, got %h", $time, want.value, got.value);
            n_mismatch++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_rmw(in_tuser[CMD_W-1:0], in_tdata[LOC_W-1:0],
                         in_tdata[LOC_W +: DATA_W], in_tdata[LOC_W+DATA_W +: DATA_W],
                         in_tuser[CMD_W +: BOP_W]);
        pending_results = {pending_results, want};
        if (want.status != ST_OK) begin
          n_flag++;
        end else if (in_tuser[CMD_W-1:0] == CMD_CAS) begin
          if (want.success) begin
            n_hit++;
          end else begin
            n_miss++;
          end
        end
      end
    end
    mismatches <= n_mismatch;
    awaiting <= pending_results.size();
    results_checked <= n_checked;
    swap_hits <= n_hit;
    swap_misses <= n_miss;
    flagged <= n_flag;
  end

endmodule

// ===== verif/atomic_location_rmw_unit_tb.sv =====
module atomic_location_rmw_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alrmw_pkg::*;

  // Codes the package leaves unnamed: the undefined command and the
  // range of fetch-op kinds the unit does not know.
  localparam logic [CMD_W-1:0] CMD_UNDEF    = 2'd3;
  localparam logic [BOP_W-1:0] OP_BAD_FIRST = 3'd5;
  localparam logic [BOP_W-1:0] OP_BAD_LAST  = 3'd7;

  localparam logic [LOC_W-1:0] NULL_LOC = '0;
  localparam logic [LOC_W-1:0] TOP_LOC  = LOC_W'(LOC_SPAN - 1);

  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_LIMIT   = 6000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 10;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tready = 1'b0;
  wire logic              in_tready;
  wire logic              out_tvalid;
  wire logic [OUT_TDATA_W-1:0] out_tdata;
  wire logic [OUT_TUSER_W-1:0] out_tuser;

  int mismatches, awaiting, results_checked, swap_hits, swap_misses, flagged;
  int beats_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;

  atomic_location_rmw_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rmw_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .results_checked (results_checked),
    .swap_hits       (swap_hits),
    .swap_misses     (swap_misses),
    .flagged         (flagged)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Send one command beat; bursts of random length with random gaps.
  task automatic offer_beat(
    input logic [CMD_W-1:0]  cmd,
    input logic [LOC_W-1:0]  loc,
    input logic [DATA_W-1:0] operand,
    input logic [DATA_W-1:0] compare,
    input logic [BOP_W-1:0]  bop
  );
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({compare, operand, loc});
    in_tuser <= {bop, cmd};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    beats_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  // Mostly a few busy locations so that commands find earlier stores.
  function automatic logic [LOC_W-1:0] pool_loc();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return NULL_LOC;
    if (pick <= 2) return TOP_LOC - LOC_W'($urandom_range(0, 2));
    return LOC_W'($urandom_range(1, 24));
  endfunction

  // Random word with the all-zero and all-one edges mixed in.
  function automatic logic [DATA_W-1:0] any_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: stall patterns that change every so often, plus one long
  // hold-off while the sender keeps offering beats.
  initial begin : receiver
    rx_mode_t mode;
    int span;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 120);
      repeat (span) begin
        if (!hold_done && results_checked >= 400) begin
          hold_done = 1'b1;
          out_tready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= ~out_tready;
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: give up when no beat has moved on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [LOC_W-1:0]  loc;
    logic [DATA_W-1:0] first_val;
    logic [DATA_W-1:0] second_val;
    logic [BOP_W-1:0]  fop_kind;
    int unsigned pick;
    int random_goal;
    bit paused_mid;
    paused_mid = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Commands on a location that was never stored.
    offer_beat(CMD_CAS, 10'd5, 32'h0000_0001, 32'h0000_0000, OP_ADD);
    offer_beat(CMD_FOP, 10'd5, 32'h0000_0001, 32'h0000_0000, OP_ADD);
    // Every command on the null location, the undefined one included.
    offer_beat(CMD_STORE, NULL_LOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_BAD_LAST);
    offer_beat(CMD_CAS, NULL_LOC, 32'h0000_0000, 32'h0000_0000, OP_ADD);
    offer_beat(CMD_FOP, NULL_LOC, 32'h0000_0001, 32'h0000_0000, OP_XOR);
    offer_beat(CMD_UNDEF, NULL_LOC, 32'h0000_0000, 32'h0000_0000, OP_ADD);
    offer_beat(CMD_UNDEF, 10'd7, 32'h1234_5678, 32'h0000_0000, OP_ADD);
    // Wrap-around of add and subtract at the top location.
    offer_beat(CMD_STORE, TOP_LOC, 32'hFFFF_FFFF, 32'h0000_0000, OP_ADD);
    offer_beat(CMD_FOP, TOP_LOC, 32'h0000_0001, 32'h0000_0000, OP_ADD);
    offer_beat(CMD_FOP, TOP_LOC, 32'h0000_0001, 32'h0000_0000, OP_SUB);
    offer_beat(CMD_FOP, TOP_LOC, 32'hFFFF_FFFF, 32'h0000_0000, OP_SUB);
    // Logic kinds, the unknown kinds, then a swap miss and two hits.
    offer_beat(CMD_STORE, 10'd1, 32'hA5A5_F00F, 32'hFFFF_FFFF, OP_ADD);
    offer_beat(CMD_FOP, 10'd1, 32'h0FF0_FF00, 32'h0000_0000, OP_AND);
    offer_beat(CMD_FOP, 10'd1, 32'hF000_000F, 32'h0000_0000, OP_OR);
    offer_beat(CMD_FOP, 10'd1, 32'hFFFF_FFFF, 32'h0000_0000, OP_XOR);
    for (int k = OP_BAD_FIRST; k <= OP_BAD_LAST; k++) begin
      offer_beat(CMD_FOP, 10'd1, 32'h0000_0001, 32'h0000_0000, BOP_W'(k));
    end
    offer_beat(CMD_CAS, 10'd1, 32'hDEAD_BEEF, 32'hFFFF_FFFF, OP_ADD);
    offer_beat(CMD_CAS, 10'd1, 32'h1234_5678, 32'h0A5F_0FF0, OP_ADD);
    offer_beat(CMD_CAS, 10'd1, 32'h0000_0000, 32'h1234_5678, OP_ADD);
    offer_beat(CMD_STORE, TOP_LOC, 32'h0000_0000, 32'hFFFF_FFFF, OP_BAD_LAST);
    offer_beat(CMD_UNDEF, 10'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_BAD_LAST);
    wait_for_results();

    // Random part: mostly store, swap and fetch-op chains on one location,
    // the rest fully random beats.
    random_goal = beats_sent + RANDOM_ITEMS;
    while (beats_sent < random_goal) begin
      if (!paused_mid && beats_sent >= random_goal - RANDOM_ITEMS / 2) begin
        paused_mid = 1'b1;
        wait_for_results();
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        loc = pool_loc();
        first_val = any_word();
        second_val = any_word();
        if (pick != 0) begin
          offer_beat(CMD_STORE, loc, first_val, any_word(), BOP_W'($urandom_range(0, 7)));
        end
        offer_beat(CMD_CAS, loc, second_val, first_val, BOP_W'($urandom_range(0, 7)));
        if ($urandom_range(0, 1) == 1) begin
          offer_beat(CMD_CAS, loc, any_word(), second_val, BOP_W'($urandom_range(0, 7)));
        end
        if ($urandom_range(0, 2) == 0) begin
          offer_beat(CMD_CAS, loc, any_word(), any_word(), BOP_W'($urandom_range(0, 7)));
        end
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 7) == 0) begin
            fop_kind = BOP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
          end else begin
            fop_kind = BOP_W'($urandom_range(OP_ADD, OP_XOR));
          end
          offer_beat(CMD_FOP, loc, any_word(), any_word(), fop_kind);
        end
      end else begin
        offer_beat(CMD_W'($urandom_range(0, 3)), LOC_W'($urandom_range(0, LOC_SPAN - 1)),
                   $urandom, $urandom, BOP_W'($urandom_range(0, 7)));
      end
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d command beats and checked %0d result beats.",
             beats_sent, results_checked);
    $display("Swaps that hit: %0d, swaps that missed: %0d, flagged outcomes: %0d.",
             swap_hits, swap_misses, flagged);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
